FILE: hw/rtl/sam_pkg.sv
// package for the sorted alarm multiplexer: codes, item types, sizes
`timescale 1ns / 1ps
`default_nettype none
package sam_pkg;
    localparam int SLOTS_DEF = 16;
    localparam int TIME_BITS_DEF = 48;
    localparam int SLOT_W = 4;
    localparam int TIME_W = 48;

    typedef enum logic [1:0] {
        OP_SET = 2'd0,
        OP_CLEAR = 2'd1,
        OP_PROCESS = 2'd2,
        OP_NONE = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ACT_FIRE = 2'd0,
        ACT_PROGRAM = 2'd1,
        ACT_CANCEL = 2'd2,
        ACT_RSVD = 2'd3
    } action_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] time_value;
    } cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic [SLOT_W-1:0] fired_slot;
        logic [TIME_W-1:0] alarm_time;
        logic last;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_FWD,
        ST_BACK,
        ST_SHIFT,
        ST_FIRE,
        ST_FINISH
    } state_t;
endpackage
`default_nettype wire

FILE: hw/rtl/sam_front.sv
// front end: takes command items, screens out no-op ones, holds a short queue
`timescale 1ns / 1ps
`default_nettype none
module sam_front #(
    parameter int SLOTS = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire sam_pkg::cmd_t command,
    output logic               busy,
    output logic               q_valid,
    output sam_pkg::cmd_t      q_cmd,
    input  wire logic          q_pop
);
    import sam_pkg::*;

    // two-entry queue
    cmd_t q_mem_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic rd_reg, rd_next, wr_reg, wr_next;
    logic push;
    logic useful;

    // screen: unused opcode or out of range slot never does anything
    always_comb
    begin
        useful = 1'b1;
        if (command.opcode == OP_NONE)
            useful = 1'b0;
        else if (command.opcode != OP_PROCESS && 32'(command.slot) >= SLOTS)
            useful = 1'b0;
    end

    assign busy = (cnt_reg == 2'd2);
    assign push = start && !busy && useful;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd = q_mem_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg + 2'(push) - 2'(q_pop);
        rd_next = rd_reg ^ q_pop;
        wr_next = wr_reg ^ push;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg <= 1'b0;
            wr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rd_reg <= rd_next;
            wr_reg <= wr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem_reg[wr_reg] <= command;
    end

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid) else $error("pop from empty queue");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue count overflow");
    a_full_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2 && !q_pop) |=> busy) else $error("full queue not busy");
`endif
endmodule
`default_nettype wire

FILE: hw/rtl/sam_back.sv
// back end: sorted slot list, one list position per cycle
`timescale 1ns / 1ps
`default_nettype none
module sam_back #(
    parameter int SLOTS = 16,
    parameter int TIME_BITS = 48
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_valid,
    input  wire sam_pkg::cmd_t  q_cmd,
    output logic                q_pop,
    output logic                res_valid,
    output sam_pkg::result_t    res
);
    import sam_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    logic [TIME_BITS-1:0] trig_reg [SLOTS];
    logic [SLOTS-1:0] armed_reg, armed_next;
    logic [IW-1:0] rank_reg [SLOTS];
    logic [CW-1:0] n_reg, n_next;
    state_t st_reg, st_next;
    logic [1:0] op_reg;
    logic [IW-1:0] s_reg;
    logic [TIME_BITS-1:0] t_reg;
    logic [TIME_BITS-1:0] old_reg;
    logic none_reg;
    logic [CW-1:0] p_reg, p_next;
    logic [CW-1:0] j_reg, j_next;
    logic res_valid_reg, res_valid_next;
    result_t res_reg, res_next;

    // shift kinds
    logic do_remove, do_insert, rank_wr_one;
    logic [IW-1:0] rank_wr_idx, rank_wr_val;
    logic trig_wr;
    logic phase_ins_reg, phase_ins_next;
    state_t st_go;

    logic [IW-1:0] s_in;
    logic [TIME_BITS-1:0] t_in;
    logic [TIME_BITS-1:0] head_t;
    logic [IW-1:0] pidx, pm1idx, jidx;
    logic [TIME_BITS-1:0] tp, tpm1;

    assign s_in = IW'(q_cmd.slot);
    assign t_in = TIME_BITS'(q_cmd.time_value);
    assign head_t = trig_reg[rank_reg[0]];
    assign pidx = p_reg[IW-1:0];
    assign pm1idx = IW'(p_reg - CW'(1));
    assign jidx = j_reg[IW-1:0];
    assign tp = trig_reg[rank_reg[pidx]];
    assign tpm1 = trig_reg[rank_reg[pm1idx]];

    // next state
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_cmd.opcode)
                        OP_SET:
                        begin
                            if (armed_reg[s_in] && trig_reg[s_in] == t_in)
                                st_next = ST_IDLE;
                            else if (armed_reg[s_in])
                                st_next = ST_FIND;
                            else
                                st_next = ST_FWD;
                        end
                        OP_CLEAR:
                            st_next = armed_reg[s_in] ? ST_FIND : ST_IDLE;
                        OP_PROCESS:
                            st_next = ST_FIRE;
                        default:
                            st_next = ST_IDLE;
                    endcase
                end
            end
            ST_FIND:
                if (rank_reg[pidx] == s_reg)
                    st_next = ST_SHIFT;
            ST_FWD:
                if (!(p_reg < n_reg && t_reg > tp))
                    st_next = ST_BACK;
            ST_BACK:
                if (!(p_reg != '0 && t_reg < tpm1))
                    st_next = ST_SHIFT;
            ST_SHIFT:
                if ((do_remove && j_reg + CW'(1) >= n_reg)
                    || (do_insert && j_reg <= p_reg))
                begin
                    if (do_remove && op_reg == OP_SET)
                        st_next = ST_FWD;
                    else if (do_remove && op_reg == OP_PROCESS)
                        st_next = ST_FIRE;
                    else
                        st_next = ST_FINISH;
                end
            ST_FIRE:
                if (!(n_reg != '0 && t_reg >= head_t))
                    st_next = ST_IDLE;
            ST_FINISH:
                st_next = ST_IDLE;
            default:
                st_next = ST_IDLE;
        endcase
    end

    // remove phase is the shift that follows find or a fire; insert follows back
    assign do_insert = (st_reg == ST_SHIFT) && phase_ins_reg;
    assign do_remove = (st_reg == ST_SHIFT) && !phase_ins_reg;

    // outputs and datapath control
    always_comb
    begin
        armed_next = armed_reg;
        n_next = n_reg;
        p_next = p_reg;
        j_next = j_reg;
        phase_ins_next = phase_ins_reg;
        res_valid_next = 1'b0;
        res_next = '0;
        q_pop = 1'b0;
        rank_wr_one = 1'b0;
        rank_wr_idx = '0;
        rank_wr_val = '0;
        trig_wr = 1'b0;
        unique case (st_reg)
            ST_IDLE:
            begin
                p_next = '0;
                j_next = '0;
                q_pop = q_valid;
                phase_ins_next = 1'b0;
                if (q_valid && q_cmd.opcode == OP_SET && !armed_reg[s_in])
                begin
                    armed_next[s_in] = 1'b1;
                    trig_wr = 1'b1;
                end
            end
            ST_FIND:
                if (rank_reg[pidx] == s_reg)
                    j_next = p_reg;
                else
                    p_next = p_reg + CW'(1);
            ST_FWD:
            begin
                trig_wr = 1'b1;
                if (p_reg < n_reg && t_reg > tp)
                    p_next = p_reg + CW'(1);
            end
            ST_BACK:
                if (p_reg != '0 && t_reg < tpm1)
                    p_next = p_reg - CW'(1);
                else
                begin
                    phase_ins_next = 1'b1;
                    j_next = n_reg;
                end
            ST_SHIFT:
            begin
                if (do_insert)
                begin
                    rank_wr_one = 1'b1;
                    rank_wr_idx = jidx;
                    if (j_reg <= p_reg)
                    begin
                        rank_wr_val = s_reg;
                        n_next = n_reg + CW'(1);
                    end
                    else
                        rank_wr_val = rank_reg[IW'(j_reg - CW'(1))];
                    if (!(j_reg == '0 || j_reg <= p_reg))
                        j_next = j_reg - CW'(1);
                end
                else
                begin
                    if (j_reg + CW'(1) < n_reg)
                    begin
                        rank_wr_one = 1'b1;
                        rank_wr_idx = jidx;
                        rank_wr_val = rank_reg[IW'(j_reg + CW'(1))];
                        j_next = j_reg + CW'(1);
                    end
                    else
                    begin
                        n_next = n_reg - CW'(1);
                        if (op_reg == OP_CLEAR)
                            armed_next[s_reg] = 1'b0;
                        if (op_reg == OP_SET)
                            p_next = p_reg;
                    end
                end
            end
            ST_FIRE:
                if (n_reg != '0 && t_reg >= head_t)
                begin
                    armed_next[rank_reg[0]] = 1'b0;
                    res_valid_next = 1'b1;
                    res_next.action = ACT_FIRE;
                    res_next.fired_slot = SLOT_W'(rank_reg[0]);
                    j_next = '0;
                    phase_ins_next = 1'b0;
                end
                else
                begin
                    res_valid_next = 1'b1;
                    res_next.last = 1'b1;
                    if (n_reg == '0)
                        res_next.action = ACT_CANCEL;
                    else
                    begin
                        res_next.action = ACT_PROGRAM;
                        res_next.alarm_time = TIME_W'(head_t);
                    end
                end
            ST_FINISH:
            begin
                res_next.last = 1'b1;
                if (n_reg == '0)
                begin
                    res_valid_next = 1'b1;
                    res_next.action = ACT_CANCEL;
                end
                else if (none_reg || head_t != old_reg)
                begin
                    res_valid_next = 1'b1;
                    res_next.action = ACT_PROGRAM;
                    res_next.alarm_time = TIME_W'(head_t);
                end
            end
            default: ;
        endcase
    end

    // a fire goes to a remove shift from position zero
    always_comb
    begin
        st_go = st_next;
        if (st_reg == ST_FIRE && n_reg != '0 && t_reg >= head_t)
            st_go = ST_SHIFT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            armed_reg <= '0;
            n_reg <= '0;
            res_valid_reg <= 1'b0;
            phase_ins_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_go;
            armed_reg <= armed_next;
            n_reg <= n_next;
            res_valid_reg <= res_valid_next;
            phase_ins_reg <= phase_ins_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
        j_reg <= j_next;
        res_reg <= res_next;
        if (st_reg == ST_IDLE && q_valid)
        begin
            op_reg <= q_cmd.opcode;
            s_reg <= s_in;
            t_reg <= t_in;
            none_reg <= (n_reg == '0);
            old_reg <= head_t;
        end
        if (rank_wr_one)
            rank_reg[rank_wr_idx] <= rank_wr_val;
        if (trig_wr)
            trig_reg[st_reg == ST_IDLE ? s_in : s_reg] <= st_reg == ST_IDLE ? t_in : t_reg;
    end

    assign res_valid = res_valid_reg;
    assign res = res_reg;

`ifndef SYNTHESIS
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= CW'(SLOTS)) else $error("list count above slot count");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> st_reg == ST_IDLE) else $error("pop outside idle");
    a_fire_slot_armed: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_FIRE && n_reg != '0 && t_reg >= head_t)
        |=> !armed_reg[$past(rank_reg[0])]) else $error("fired slot still armed");
`endif
endmodule
`default_nettype wire

FILE: hw/rtl/sorted_alarm_multiplexer.sv
// top level of the sorted alarm multiplexer
`timescale 1ns / 1ps
`default_nettype none
// sorted alarm multiplexer: keeps alarm slots in trigger order and drives
// one hardware alarm from the earliest of them
// command channel: an item (opcode, slot, time_value) is taken at a clock
//   edge with start high and busy low; a two-item queue sits behind it
// result channel: result_valid marks each result for one cycle, the
//   receiver has no way to stall, so every result is taken as shown
// an item gives 0 to 17 results: set gives at most a program, clear a
//   program or cancel, process a fire per due slot then program or cancel
// timing: the back end walks the list one position per cycle; a set runs
//   at most find, remove shift, search and insert shift, a clear runs find
//   and remove shift, a process a remove shift per fired slot; results are
//   registered and appear in the cycle after the step that makes them
// unused opcodes and out of range slots are dropped at the front end
// reset clears the armed flags, the list count and the queue; times and
//   list entries are not cleared, they are read only once written
module sorted_alarm_multiplexer #(
    parameter int SLOTS = sam_pkg::SLOTS_DEF,
    parameter int TIME_BITS = sam_pkg::TIME_BITS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire sam_pkg::cmd_t    command,
    output logic                  result_valid,
    output sam_pkg::result_t      result
);
    import sam_pkg::*;

    logic q_valid, q_pop;
    cmd_t q_cmd;

    // front end: screen and queue
    sam_front #(.SLOTS(SLOTS)) u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .command(command),
        .busy(busy), .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
    );

    // back end: ordered list walk
    sam_back #(.SLOTS(SLOTS), .TIME_BITS(TIME_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_cmd(q_cmd),
        .q_pop(q_pop), .res_valid(result_valid), .res(result)
    );
endmodule
`default_nettype wire

FILE: bench/sam_checker.sv
// result checker for the sorted alarm multiplexer: predicts and compares results
`timescale 1ns / 1ps
`default_nettype none
module sam_checker
    import sam_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire logic    busy,
    input  wire cmd_t    command,
    input  wire logic    result_valid,
    input  wire result_t result,
    output int           fail_count,
    output int           pending,
    output int           result_count,
    output int           fire_count
);
    logic [TIME_W-1:0] trig [16];
    logic              armed [16];
    logic [3:0]        rank [16];
    result_t           expected_q [$];

    function automatic int live();
        int n;
        n = 0;
        for (int i = 0; i < 16; i++)
            n += armed[i];
        return n;
    endfunction

    function automatic void drop_pos(int pos, int n);
        for (int i = pos; i + 1 < n; i++)
            rank[i] = rank[i + 1];
    endfunction

    function automatic void push(logic [1:0] a, logic [3:0] s, logic [TIME_W-1:0] t,
                                 logic l);
        result_t r;
        r.action = a;
        r.fired_slot = s;
        r.alarm_time = t;
        r.last = l;
        expected_q.push_back(r);
    endfunction

    function automatic void predict_alarms(cmd_t c);
        int n, p;
        logic [TIME_W-1:0] old, t;
        logic [3:0] s, f;
        bit none;
        n = live();
        none = (n == 0);
        old = none ? '0 : trig[rank[0]];
        s = c.slot;
        t = c.time_value;
        p = 0;
        case (opcode_t'(c.opcode))
            OP_SET:
            begin
                if (armed[s] && trig[s] == t)
                    return;
                if (armed[s])
                begin
                    for (int i = 0; i < n; i++)
                        if (rank[i] == s)
                            p = i;
                    drop_pos(p, n);
                    n--;
                end
                armed[s] = 1'b1;
                trig[s] = t;
                while (p < n && t > trig[rank[p]])
                    p++;
                while (p > 0 && t < trig[rank[p-1]])
                    p--;
                for (int i = n; i > p; i--)
                    rank[i] = rank[i-1];
                rank[p] = s;
                if (none || trig[rank[0]] != old)
                    push(ACT_PROGRAM, '0, trig[rank[0]], 1'b1);
            end
            OP_CLEAR:
            begin
                if (!armed[s])
                    return;
                for (int i = 0; i < n; i++)
                    if (rank[i] == s)
                        p = i;
                drop_pos(p, n);
                n--;
                armed[s] = 1'b0;
                if (n == 0)
                    push(ACT_CANCEL, '0, '0, 1'b1);
                else if (trig[rank[0]] != old)
                    push(ACT_PROGRAM, '0, trig[rank[0]], 1'b1);
            end
            OP_PROCESS:
            begin
                while (n > 0 && t >= trig[rank[0]])
                begin
                    f = rank[0];
                    drop_pos(0, n);
                    n--;
                    armed[f] = 1'b0;
                    push(ACT_FIRE, f, '0, 1'b0);
                end
                if (n == 0)
                    push(ACT_CANCEL, '0, '0, 1'b1);
                else
                    push(ACT_PROGRAM, '0, trig[rank[0]], 1'b1);
            end
            default: ;
        endcase
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        result_t e;
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
                armed[i] = 1'b0;
            expected_q.delete();
            fail_count <= 0;
            result_count <= 0;
            fire_count <= 0;
        end
        else
        begin
            if (result_valid)
            begin
                result_count <= result_count + 1;
                if (result.action == ACT_FIRE)
                    fire_count <= fire_count + 1;
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, result);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (e.action != result.action || e.fired_slot != result.fired_slot ||
                        e.alarm_time != result.alarm_time || e.last != result.last)
                    begin
                        $display("%0t: mismatch, expected act=%0d slot=%0d time=%h last=%0b",
                                 $time, e.action, e.fired_slot, e.alarm_time, e.last);
                        $display("%0t:           actual act=%0d slot=%0d time=%h last=%0b",
                                 $time, result.action, result.fired_slot,
                                 result.alarm_time, result.last);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy)
                predict_alarms(command);
        end
    end
endmodule
`default_nettype wire

FILE: bench/tb.sv
// testbench top for the sorted alarm multiplexer: stimulus and verdict
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import sam_pkg::*;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    cmd_t    command = '0;
    logic    busy;
    logic    result_valid;
    result_t result;
    int      fail_count, pending, result_count, fire_count;
    int      idle_pct = 0;
    int      stall_cycles = 0;
    int      item_count = 0;
    // software copy of what is armed, so sets can repeat the time of a live slot
    logic [TIME_W-1:0] shadow_time [16];
    logic              shadow_armed [16];
    logic [TIME_W-1:0] now_time = 48'd1000;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    sorted_alarm_multiplexer dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .command(command), .result_valid(result_valid), .result(result)
    );

    sam_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .command(command),
        .result_valid(result_valid), .result(result), .fail_count(fail_count),
        .pending(pending), .result_count(result_count), .fire_count(fire_count)
    );

    // watchdog: any cycle with no item or result accepted counts toward the limit
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || !rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > 20000)
        begin
            $display("watchdog expired");
            $display("== FAIL ==");
            $finish;
        end
    end

    // hand one item to the block, with a random gap first; track the mirror
    task automatic send_item(logic [1:0] op, logic [3:0] s, logic [TIME_W-1:0] t);
        logic took;
        while ($urandom_range(99, 0) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        command <= '{opcode: op, slot: s, time_value: t};
        took = 1'b0;
        // busy is settled mid cycle, so it tells whether the next edge takes the item
        while (!took)
        begin
            @(negedge clk);
            took = !busy;
            @(posedge clk);
        end
        item_count++;
        case (opcode_t'(op))
            OP_SET:
            begin
                shadow_armed[s] = 1'b1;
                shadow_time[s] = t;
            end
            OP_CLEAR: shadow_armed[s] = 1'b0;
            OP_PROCESS:
                for (int i = 0; i < 16; i++)
                    if (shadow_armed[i] && shadow_time[i] <= t)
                        shadow_armed[i] = 1'b0;
            default: ;
        endcase
    endtask

    // wait for every expected result, then give the back end time to settle
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // one random item: mostly sets near the running clock, with clears,
    // processes, repeats of a live time, and a bit of noise
    task automatic random_item();
        int pick;
        logic [3:0] s;
        logic [TIME_W-1:0] t;
        pick = $urandom_range(99, 0);
        s = 4'($urandom_range(15, 0));
        t = now_time + $urandom_range(200, 0);
        if (pick < 45)
        begin
            if ($urandom_range(9, 0) == 0)
                t = 48'({$urandom, $urandom});
            send_item(OP_SET, s, t);
        end
        else if (pick < 55)
        begin
            if (shadow_armed[s])
                send_item(OP_SET, s, shadow_time[s]);
            else
                send_item(OP_SET, s, now_time + 48'd50);
        end
        else if (pick < 70)
            send_item(OP_CLEAR, s, 48'({$urandom, $urandom}));
        else if (pick < 95)
        begin
            now_time = now_time + 48'($urandom_range(120, 0));
            send_item(OP_PROCESS, s, now_time);
        end
        else
            send_item(OP_NONE, s, 48'({$urandom, $urandom}));
    endtask

    initial
    begin
        for (int i = 0; i < 16; i++)
            shadow_armed[i] = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty list cases, extremes of time and slot, ties
        send_item(OP_PROCESS, 4'd0, 48'd0);
        send_item(OP_CLEAR, 4'd3, 48'd0);
        send_item(OP_SET, 4'd15, 48'hFFFF_FFFF_FFFF);
        send_item(OP_SET, 4'd0, 48'd0);
        send_item(OP_SET, 4'd0, 48'd0);
        send_item(OP_SET, 4'd5, 48'd0);
        send_item(OP_SET, 4'd7, 48'd100);
        send_item(OP_SET, 4'd9, 48'd100);
        send_item(OP_SET, 4'd5, 48'd100);
        send_item(OP_SET, 4'd0, 48'hAAAA_AAAA_AAAA);
        send_item(OP_SET, 4'd10, 48'h5555_5555_5555);
        send_item(OP_NONE, 4'd1, 48'h1234);
        send_item(OP_CLEAR, 4'd2, 48'd0);
        send_item(OP_CLEAR, 4'd7, 48'd0);
        send_item(OP_PROCESS, 4'd0, 48'd99);
        send_item(OP_PROCESS, 4'd0, 48'd100);
        send_item(OP_CLEAR, 4'd15, 48'd0);
        send_item(OP_PROCESS, 4'd0, 48'hFFFF_FFFF_FFFF);
        // fill every slot, then fire all of them in one process
        for (int i = 0; i < 16; i++)
            send_item(OP_SET, i[3:0], 48'd900 + 48'(($urandom_range(3, 0))));
        send_item(OP_PROCESS, 4'd0, 48'd1000);

        // pause until every expected result has come
        drain();

        // three random phases: sender idles 14 percent, then 79, then never
        for (int ph = 0; ph < 3; ph++)
        begin
            idle_pct = (ph == 0) ? 14 : (ph == 1) ? 79 : 0;
            for (int j = 0; j < 58; j++)
                random_item();
            drain();
        end
        // flush everything still armed
        send_item(OP_PROCESS, 4'd0, 48'hFFFF_FFFF_FFFF);
        drain();

        $display("sent %0d items, checked %0d results of which %0d fired alarms",
                 item_count, result_count, fire_count);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire

FILE: sim.f
hw/rtl/sam_pkg.sv
hw/rtl/sam_front.sv
hw/rtl/sam_back.sv
hw/rtl/sorted_alarm_multiplexer.sv
bench/sam_checker.sv
bench/tb.sv
